// ===== hw/rtl/tap_tempo_footswitch_controller_macros.svh =====
// Assertion helpers shared by the controller RTL.
`ifndef TAP_TEMPO_FOOTSWITCH_CONTROLLER_MACROS_SVH
`define TAP_TEMPO_FOOTSWITCH_CONTROLLER_MACROS_SVH

// Same-cycle implication.
`define TTFC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ttfc assertion failed");

// Next-cycle implication.
`define TTFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ttfc assertion failed");

`endif

// ===== hw/rtl/ttfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ttfc_pkg;

  // Config port geometry
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_SAMPLE_RATE = 3'd0;
  localparam logic [2:0] REG_TAP_MIN     = 3'd1;
  localparam logic [2:0] REG_TAP_TIMEOUT = 3'd2;
  localparam logic [2:0] REG_HOLD        = 3'd3;
  localparam logic [2:0] REG_MAX_DELAY   = 3'd4;

  localparam logic [17:0] RST_SAMPLE_RATE = 18'd48000;
  localparam logic [11:0] RST_TAP_MIN     = 12'd100;
  localparam logic [11:0] RST_TAP_TIMEOUT = 12'd2000;
  localparam logic [15:0] RST_HOLD        = 16'd500;
  localparam logic [19:0] RST_MAX_DELAY   = 20'd480000;

  localparam logic [9:0] MS_PER_S = 10'd1000;

  // Toggle positions
  localparam logic [1:0] TGL_UP   = 2'd0;
  localparam logic [1:0] TGL_MID  = 2'd1;
  localparam logic [1:0] TGL_DOWN = 2'd2;

  // Mode codes
  localparam logic [1:0] PITCH_UNITY  = 2'd0;
  localparam logic [1:0] PITCH_FIFTH  = 2'd1;
  localparam logic [1:0] PITCH_OCTAVE = 2'd2;
  localparam logic [1:0] FILT_POST    = 2'd0;
  localparam logic [1:0] FILT_PRE     = 2'd1;
  localparam logic [1:0] FILT_LOOP    = 2'd2;
  localparam logic [1:0] LOFI_CLEAN   = 2'd0;
  localparam logic [1:0] LOFI_SOFT    = 2'd1;
  localparam logic [1:0] LOFI_CRUSH   = 2'd2;

  typedef struct packed {
    logic [17:0] sample_rate_hz;
    logic [11:0] tap_floor_ms;
    logic [11:0] tap_limit_ms;
    logic [15:0] hold_ms;
    logic [19:0] delay_cap;
  } ttfc_cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        fs1_rise;
    logic        fs1_down;
    logic        fs2_rise;
    logic        fs2_down;
    logic        fs2_fall;
    logic [15:0] fs2_held_ms;
    logic [1:0]  toggle_one;
    logic [1:0]  toggle_two;
    logic [1:0]  toggle_three;
    logic        knob_moved;
  } ttfc_in_t;

  typedef struct packed {
    logic        delay_on;
    logic        freeze_on;
    logic        send_gate;
    logic        tap_on;
    logic [19:0] tap_samples;
    logic [1:0]  pitch_mode;
    logic [1:0]  filter_place;
    logic [1:0]  lofi_mode;
    logic        blink_start;
  } ttfc_out_t;

  // Controller -> datapath
  typedef struct packed {
    logic load_in;
    logic eval;
    logic sum_step;
    logic mul;
    logic div_step;
    logic clamp;
    logic load_out;
  } ttfc_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic rec;
    logic sum_last;
    logic div_last;
    logic out_free;
  } ttfc_sts_t;

  // Pitch: middle is 1.5, down is 2.0, anything else unity
  function automatic logic [1:0] pitch_of(input logic [1:0] t);
    logic [1:0] m;
    m = (t == TGL_MID) ? PITCH_FIFTH : (t == TGL_DOWN) ? PITCH_OCTAVE : PITCH_UNITY;
    return m;
  endfunction

  // Three-way map where the unused code acts as down
  function automatic logic [1:0] three_way(input logic [1:0] t, input logic [1:0] c_up,
                                           input logic [1:0] c_mid, input logic [1:0] c_dn);
    logic [1:0] m;
    m = (t == TGL_UP) ? c_up : (t == TGL_MID) ? c_mid : c_dn;
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ttfc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface ttfc_in_if import ttfc_pkg::*;
  ;
  logic     valid;
  logic     ready;
  ttfc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ttfc_out_if import ttfc_pkg::*;
  ;
  logic      valid;
  logic      ready;
  ttfc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ttfc_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ttfc_regs import ttfc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output ttfc_cfg_t              cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_rate_hz <= RST_SAMPLE_RATE;
      cfg.tap_floor_ms   <= RST_TAP_MIN;
      cfg.tap_limit_ms   <= RST_TAP_TIMEOUT;
      cfg.hold_ms        <= RST_HOLD;
      cfg.delay_cap      <= RST_MAX_DELAY;
    end else if (wr) begin
      case (idx)
        REG_SAMPLE_RATE: cfg.sample_rate_hz <= pwdata[17:0];
        REG_TAP_MIN:     cfg.tap_floor_ms   <= pwdata[11:0];
        REG_TAP_TIMEOUT: cfg.tap_limit_ms   <= pwdata[11:0];
        REG_HOLD:        cfg.hold_ms        <= pwdata[15:0];
        REG_MAX_DELAY:   cfg.delay_cap      <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SAMPLE_RATE: prdata = {14'd0, cfg.sample_rate_hz};
      REG_TAP_MIN:     prdata = {20'd0, cfg.tap_floor_ms};
      REG_TAP_TIMEOUT: prdata = {20'd0, cfg.tap_limit_ms};
      REG_HOLD:        prdata = {16'd0, cfg.hold_ms};
      REG_MAX_DELAY:   prdata = {12'd0, cfg.delay_cap};
      default:         prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ttfc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "tap_tempo_footswitch_controller_macros.svh"
module ttfc_ctrl import ttfc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  ttfc_sts_t      sts,
  output ttfc_cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EVAL  = 7'b0000010,
    S_SUM   = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_CLAMP = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.rec ? S_SUM : S_DONE;
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.sum_last) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `TTFC_ASSERT_NEXT(a_accept_to_eval, clk, rst, in_valid && in_ready, state == S_EVAL)
  `TTFC_ASSERT_NEXT(a_no_tap_skips_math, clk, rst, state == S_EVAL && !sts.rec, state == S_DONE)
  `TTFC_ASSERT_IMPL(a_state_onehot, clk, rst, 1'b1, $onehot(state))

endmodule
`default_nettype wire

// ===== hw/rtl/ttfc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "tap_tempo_footswitch_controller_macros.svh"
module ttfc_dp import ttfc_pkg::*; #(
  parameter int TAP_HISTORY = 3
) (
  input  wire logic clk,
  input  wire logic rst,
  input  ttfc_cfg_t cfg,
  input  ttfc_cmd_t cmd,
  output ttfc_sts_t sts,
  input  ttfc_in_t  in_data,
  input  wire logic out_ready,
  output logic      out_valid,
  output ttfc_out_t out_data
);

  localparam int CNT_W  = $clog2(TAP_HISTORY + 1);
  localparam int IDX_W  = (TAP_HISTORY > 1) ? $clog2(TAP_HISTORY) : 1;
  localparam int SUM_W  = 12 + $clog2(TAP_HISTORY);
  localparam int PROD_W = SUM_W + 18;
  localparam int DIV_W  = CNT_W + 10;
  localparam int ITER_W = $clog2(PROD_W);

  ttfc_in_t in_q;

  // scan state
  logic              tap_waiting, tap_active, effect_active, freeze_hold;
  logic              long_press_done, suppress_release;
  logic [31:0]       last_tap_time;
  logic [11:0]       ints [TAP_HISTORY];
  logic [CNT_W-1:0]  interval_count;
  logic [19:0]       tapped_delay;
  logic [1:0]        last_tog [3];
  logic [1:0]        pitch_setting, filter_setting, lofi_setting;
  logic              sg_q, blink_q;

  // averaging datapath
  logic [CNT_W-1:0]  avg_cnt;
  logic [ITER_W-1:0] iter;
  logic [SUM_W-1:0]  sum;
  logic [DIV_W-1:0]  divisor;
  logic [DIV_W-1:0]  rem;
  logic [PROD_W-1:0] quo;

  // next values from one scan
  logic              tw, ta, eff, frz, lpd, sup, sg, blk, rec;
  logic [31:0]       ltt, gap;
  logic [11:0]       ints_next [TAP_HISTORY];
  logic [CNT_W-1:0]  cnt, avgc;
  logic [1:0]        lt_next [3];
  logic [1:0]        pit, fil, lof;

  logic [DIV_W:0]    rem_sh;
  logic              q_bit;
  logic [19:0]       q_lim;

  always_comb begin
    tw   = tap_waiting;
    ta   = tap_active;
    cnt  = interval_count;
    ltt  = last_tap_time;
    eff  = effect_active;
    frz  = freeze_hold;
    lpd  = long_press_done;
    sup  = suppress_release;
    pit  = pitch_setting;
    fil  = filter_setting;
    lof  = lofi_setting;
    avgc = avg_cnt;
    blk  = 1'b0;
    rec  = 1'b0;
    ints_next = ints;
    lt_next   = last_tog;
    gap  = in_q.now_ms - last_tap_time;

    if (in_q.knob_moved && ta) begin
      tw  = 1'b0;
      ta  = 1'b0;
      cnt = '0;
    end

    if (tw && gap > {20'd0, cfg.tap_limit_ms}) begin
      tw  = 1'b0;
      cnt = '0;
    end

    if (!frz && in_q.fs1_rise) begin
      if (!tw) begin
        tw  = 1'b1;
        cnt = '0;
        ltt = in_q.now_ms;
      end else if (gap >= {20'd0, cfg.tap_floor_ms} && gap <= {20'd0, cfg.tap_limit_ms}) begin
        if (cnt < CNT_W'(TAP_HISTORY)) begin
          ints_next[cnt[IDX_W-1:0]] = gap[11:0];
          cnt = cnt + CNT_W'(1);
        end else begin
          for (int i = 0; i < TAP_HISTORY - 1; i++) ints_next[i] = ints[i+1];
          ints_next[TAP_HISTORY-1] = gap[11:0];
          cnt = CNT_W'(TAP_HISTORY);
        end
        ta   = 1'b1;
        rec  = 1'b1;
        avgc = cnt;
        ltt  = in_q.now_ms;
      end
    end

    sg = frz && in_q.fs1_down;

    if (in_q.fs2_rise) begin
      lpd = 1'b0;
      if (frz) begin
        frz = 1'b0;
        sup = 1'b1;
      end
    end

    if (in_q.fs2_down && in_q.fs2_held_ms >= cfg.hold_ms && !lpd && eff) begin
      frz = 1'b1;
      sg  = 1'b0;
      lpd = 1'b1;
    end

    if (in_q.fs2_fall) begin
      if (sup) sup = 1'b0;
      else if (!lpd && !frz) eff = !eff;
      lpd = 1'b0;
    end

    // modifier: toggle moved while footswitch one held
    if (in_q.toggle_three != lt_next[2] && in_q.fs1_down && !frz) begin
      pit = pitch_of(in_q.toggle_three);
      tw = 1'b0; ta = 1'b0; cnt = '0; blk = 1'b1;
    end
    lt_next[2] = in_q.toggle_three;

    if (in_q.toggle_two != lt_next[1] && in_q.fs1_down && !frz) begin
      fil = three_way(in_q.toggle_two, FILT_POST, FILT_PRE, FILT_LOOP);
      tw = 1'b0; ta = 1'b0; cnt = '0; blk = 1'b1;
    end
    lt_next[1] = in_q.toggle_two;

    if (in_q.toggle_one != lt_next[0] && in_q.fs1_down && !frz) begin
      lof = three_way(in_q.toggle_one, LOFI_CLEAN, LOFI_SOFT, LOFI_CRUSH);
      tw = 1'b0; ta = 1'b0; cnt = '0; blk = 1'b1;
    end
    lt_next[0] = in_q.toggle_one;
  end

  // restoring divide, one quotient bit per step
  assign rem_sh = {rem, quo[PROD_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, divisor});
  assign q_lim  = (quo > PROD_W'(cfg.delay_cap)) ? cfg.delay_cap : quo[19:0];

  assign sts.rec      = rec;
  assign sts.sum_last = (ITER_W'(avg_cnt) == iter + ITER_W'(1));
  assign sts.div_last = (iter == ITER_W'(PROD_W - 1));
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) in_q <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_waiting      <= 1'b0;
      tap_active       <= 1'b0;
      effect_active    <= 1'b0;
      freeze_hold      <= 1'b0;
      long_press_done  <= 1'b0;
      suppress_release <= 1'b0;
      last_tap_time    <= '0;
      interval_count   <= '0;
      tapped_delay     <= '0;
      last_tog         <= '{TGL_UP, TGL_UP, TGL_UP};
      pitch_setting    <= PITCH_UNITY;
      filter_setting   <= FILT_POST;
      lofi_setting     <= LOFI_CLEAN;
    end else begin
      if (cmd.eval) begin
        tap_waiting      <= tw;
        tap_active       <= ta;
        effect_active    <= eff;
        freeze_hold      <= frz;
        long_press_done  <= lpd;
        suppress_release <= sup;
        last_tap_time    <= ltt;
        interval_count   <= cnt;
        last_tog         <= lt_next;
        pitch_setting    <= pit;
        filter_setting   <= fil;
        lofi_setting     <= lof;
      end
      if (cmd.clamp) tapped_delay <= (q_lim == '0) ? 20'd1 : q_lim;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      ints    <= ints_next;
      avg_cnt <= avgc;
      sg_q    <= sg;
      blink_q <= blk;
      sum     <= '0;
      iter    <= '0;
    end
    if (cmd.sum_step) begin
      sum  <= sum + SUM_W'(ints[iter[IDX_W-1:0]]);
      iter <= iter + ITER_W'(1);
    end
    if (cmd.mul) begin
      quo     <= PROD_W'(sum) * PROD_W'(cfg.sample_rate_hz);
      divisor <= DIV_W'(avg_cnt) * DIV_W'(MS_PER_S);
      rem     <= '0;
      iter    <= '0;
    end
    if (cmd.div_step) begin
      rem  <= q_bit ? DIV_W'(rem_sh - {1'b0, divisor}) : rem_sh[DIV_W-1:0];
      quo  <= {quo[PROD_W-2:0], q_bit};
      iter <= iter + ITER_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.delay_on     <= effect_active;
      out_data.freeze_on    <= freeze_hold;
      out_data.send_gate    <= sg_q;
      out_data.tap_on       <= tap_active;
      out_data.tap_samples  <= tapped_delay;
      out_data.pitch_mode   <= pitch_setting;
      out_data.filter_place <= filter_setting;
      out_data.lofi_mode    <= lofi_setting;
      out_data.blink_start  <= blink_q;
    end
  end

  `TTFC_ASSERT_IMPL(a_freeze_needs_effect, clk, rst, freeze_hold, effect_active)
  `TTFC_ASSERT_NEXT(a_delay_nonzero, clk, rst, cmd.clamp, tapped_delay != 20'd0)
  `TTFC_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, interval_count <= CNT_W'(TAP_HISTORY))

endmodule
`default_nettype wire

// ===== hw/rtl/tap_tempo_footswitch_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Tap tempo and footswitch controller. Each input beat is one control scan
// (ms time, footswitch edges/levels, footswitch two hold time, three toggles,
// knob flag); each scan yields exactly one output beat with bypass, freeze,
// send gate, tap state, the averaged tapped delay in samples and the three
// hidden modes. A scan that records no new tap interval goes from accept
// through evaluate straight to the result. A scan that records one adds a sum
// pass over the stored intervals, a multiply step, a bit-serial divide with
// one quotient bit per product bit (12 + clog2(TAP_HISTORY) + 18 bits, 32 at
// the default) and a clamp step. One scan is in flight at a time; the result
// sits in an output register so the next scan can be taken while it waits.
// Config registers (APB, byte address 4*i) are to be written with the block
// idle; the user must ensure this, as the block does not enforce it. They take
// effect on the next scan.
module tap_tempo_footswitch_controller import ttfc_pkg::*; #(
  parameter int TAP_HISTORY = 3
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  ttfc_in_if.sink                in_ch,
  ttfc_out_if.source             out_ch
);

  ttfc_cfg_t cfg;   // live register values
  ttfc_cmd_t cmd;   // sequencer -> datapath
  ttfc_sts_t sts;   // datapath -> sequencer

  logic      in_ready;
  logic      out_valid;
  ttfc_out_t out_data;

  // Config register bank
  ttfc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer: accept, evaluate, then the averaging math only on a new tap
  ttfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Scan state, tap history, sum/multiply/divide, result register
  ttfc_dp #(
    .TAP_HISTORY (TAP_HISTORY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_ch.data),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Scoreboard for the tap tempo / footswitch controller: scans go in on in_ch,
// the controls each scan should produce are predicted here and compared with
// every out_ch beat in order.
module tb_top;
  import ttfc_pkg::*;

  // Unused toggle code; the block must treat it per mode
  localparam logic [1:0] TGL_SPARE = 2'd3;
  localparam int HIST = 3;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  ttfc_in_if  in_ch ();
  ttfc_out_if out_ch ();

  tap_tempo_footswitch_controller dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  // ---------------------------------------------------------------------------
  // Predicted controller state and register copy
  // ---------------------------------------------------------------------------
  logic [17:0] cfg_rate;
  logic [11:0] cfg_min;
  logic [11:0] cfg_timeout;
  logic [15:0] cfg_hold;
  logic [19:0] cfg_max;

  logic        tap_waiting;
  logic        tap_live;
  logic [31:0] last_tap_ms;
  logic [11:0] ivs [0:HIST-1];
  int          n_iv;
  logic [19:0] tap_delay;
  logic        effect_on;
  logic        frozen;
  logic        long_done;
  logic        hush_release;
  logic [1:0]  last_tog [0:2];
  logic [1:0]  pitch_q;
  logic [1:0]  filt_q;
  logic [1:0]  lofi_q;

  ttfc_out_t   pending_ctl [$];
  int          mismatches;
  bit          idle_on;
  int          sink_hold;

  // Random scan generator state
  logic [31:0] gen_now;
  bit          gen_fs2_held;
  int          gen_held;
  logic [1:0]  gen_tog [0:2];

  task automatic reset_controls();
    cfg_rate     = RST_SAMPLE_RATE;
    cfg_min      = RST_TAP_MIN;
    cfg_timeout  = RST_TAP_TIMEOUT;
    cfg_hold     = RST_HOLD;
    cfg_max      = RST_MAX_DELAY;
    tap_waiting  = 1'b0;
    tap_live     = 1'b0;
    last_tap_ms  = '0;
    n_iv         = 0;
    tap_delay    = '0;
    effect_on    = 1'b0;
    frozen       = 1'b0;
    long_done    = 1'b0;
    hush_release = 1'b0;
    pitch_q      = PITCH_UNITY;
    filt_q       = FILT_POST;
    lofi_q       = LOFI_CLEAN;
    for (int i = 0; i < HIST; i++) ivs[i] = '0;
    for (int i = 0; i < 3; i++) last_tog[i] = TGL_UP;
  endtask

  function automatic void stop_tapping();
    tap_waiting = 1'b0;
    tap_live    = 1'b0;
    n_iv        = 0;
  endfunction

  // Shift in a new interval and recompute the averaged delay in samples
  function automatic void push_interval(input logic [11:0] iv);
    logic [63:0] acc;
    logic [63:0] q;
    if (n_iv < HIST) begin
      ivs[n_iv] = iv;
      n_iv++;
    end else begin
      for (int i = 0; i + 1 < HIST; i++) ivs[i] = ivs[i+1];
      ivs[HIST-1] = iv;
    end
    acc = '0;
    for (int i = 0; i < n_iv; i++) acc += 64'(ivs[i]);
    q = (acc * 64'(cfg_rate)) / (64'(n_iv) * 64'd1000);
    if (q > 64'(cfg_max)) q = 64'(cfg_max);
    if (q < 64'd1) q = 64'd1;
    tap_delay = q[19:0];
    tap_live  = 1'b1;
  endfunction

  // One control scan: same order as the block (knob, timeout, tap, gate,
  // footswitch two press/hold/release, toggles three, two, one)
  function automatic ttfc_out_t next_controls(input ttfc_in_t s);
    ttfc_out_t   o;
    logic        gate;
    logic        blink;
    logic [31:0] gap_ms;
    blink  = 1'b0;
    gap_ms = s.now_ms - last_tap_ms;
    if (s.knob_moved && tap_live) stop_tapping();
    if (tap_waiting && gap_ms > 32'(cfg_timeout)) begin
      tap_waiting = 1'b0;
      n_iv        = 0;
    end
    if (!frozen && s.fs1_rise) begin
      if (!tap_waiting) begin
        tap_waiting = 1'b1;
        n_iv        = 0;
        last_tap_ms = s.now_ms;
      end else if (gap_ms >= 32'(cfg_min) && gap_ms <= 32'(cfg_timeout)) begin
        push_interval(gap_ms[11:0]);
        last_tap_ms = s.now_ms;
      end
    end
    gate = frozen && s.fs1_down;
    if (s.fs2_rise) begin
      long_done = 1'b0;
      if (frozen) begin
        frozen       = 1'b0;
        hush_release = 1'b1;
      end
    end
    if (s.fs2_down && s.fs2_held_ms >= cfg_hold && !long_done && effect_on) begin
      frozen    = 1'b1;
      gate      = 1'b0;
      long_done = 1'b1;
    end
    if (s.fs2_fall) begin
      if (hush_release) hush_release = 1'b0;
      else if (!long_done && !frozen) effect_on = !effect_on;
      long_done = 1'b0;
    end
    if (s.toggle_three != last_tog[2] && s.fs1_down && !frozen) begin
      pitch_q = (s.toggle_three == TGL_MID)  ? PITCH_FIFTH :
                (s.toggle_three == TGL_DOWN) ? PITCH_OCTAVE : PITCH_UNITY;
      stop_tapping();
      blink = 1'b1;
    end
    last_tog[2] = s.toggle_three;
    if (s.toggle_two != last_tog[1] && s.fs1_down && !frozen) begin
      filt_q = (s.toggle_two == TGL_UP)  ? FILT_POST :
               (s.toggle_two == TGL_MID) ? FILT_PRE : FILT_LOOP;
      stop_tapping();
      blink = 1'b1;
    end
    last_tog[1] = s.toggle_two;
    if (s.toggle_one != last_tog[0] && s.fs1_down && !frozen) begin
      lofi_q = (s.toggle_one == TGL_UP)  ? LOFI_CLEAN :
               (s.toggle_one == TGL_MID) ? LOFI_SOFT : LOFI_CRUSH;
      stop_tapping();
      blink = 1'b1;
    end
    last_tog[0] = s.toggle_one;

    o              = '0;
    o.delay_on     = effect_on;
    o.freeze_on    = frozen;
    o.send_gate    = gate;
    o.tap_on       = tap_live;
    o.tap_samples  = tap_delay;
    o.pitch_mode   = pitch_q;
    o.filter_place = filt_q;
    o.lofi_mode    = lofi_q;
    o.blink_start  = blink;
    return o;
  endfunction

  function automatic logic [31:0] reg_image(input logic [2:0] idx);
    case (idx)
      REG_SAMPLE_RATE: return 32'(cfg_rate);
      REG_TAP_MIN:     return 32'(cfg_min);
      REG_TAP_TIMEOUT: return 32'(cfg_timeout);
      REG_HOLD:        return 32'(cfg_hold);
      REG_MAX_DELAY:   return 32'(cfg_max);
      default:         return '0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting and checking
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("tb: mismatch %s got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
  endtask

  task automatic check_field(input string what, input logic [19:0] got,
                             input logic [19:0] want);
    if (got !== want) note_mismatch(what, 32'(got), 32'(want));
  endtask

  // Predict on each accepted scan beat, compare each accepted control beat
  always @(posedge clk) begin
    ttfc_out_t want;
    ttfc_out_t got;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) pending_ctl.push_back(next_controls(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (pending_ctl.size() == 0) begin
          note_mismatch("beat with nothing pending", 32'(got), '0);
        end else begin
          want = pending_ctl.pop_front();
          check_field("delay_on", 20'(got.delay_on), 20'(want.delay_on));
          check_field("freeze_on", 20'(got.freeze_on), 20'(want.freeze_on));
          check_field("send_gate", 20'(got.send_gate), 20'(want.send_gate));
          check_field("tap_on", 20'(got.tap_on), 20'(want.tap_on));
          check_field("tap_samples", got.tap_samples, want.tap_samples);
          check_field("pitch_mode", 20'(got.pitch_mode), 20'(want.pitch_mode));
          check_field("filter_place", 20'(got.filter_place), 20'(want.filter_place));
          check_field("lofi_mode", 20'(got.lofi_mode), 20'(want.lofi_mode));
          check_field("blink_start", 20'(got.blink_start), 20'(want.blink_start));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (sink_hold > 0) begin
      out_ch.ready <= 1'b0;
      sink_hold--;
    end else begin
      out_ch.ready <= 1'b1;
      sink_hold = pick_gap();
    end
  end

  task automatic send_scan(input ttfc_in_t s);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= s;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and let every pending beat come back
  task automatic drain_scans();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_ctl.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SAMPLE_RATE: cfg_rate    = val[17:0];
      REG_TAP_MIN:     cfg_min     = val[11:0];
      REG_TAP_TIMEOUT: cfg_timeout = val[11:0];
      REG_HOLD:        cfg_hold    = val[15:0];
      REG_MAX_DELAY:   cfg_max     = val[19:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_readback(input logic [2:0] idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== reg_image(idx)) note_mismatch("prdata", prdata, reg_image(idx));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Block must be idle here: every pending beat already back
  task automatic set_config(input logic [31:0] rate, input logic [31:0] tmin,
                            input logic [31:0] tmo, input logic [31:0] hold,
                            input logic [31:0] dmax);
    reg_write(REG_SAMPLE_RATE, rate);
    reg_write(REG_TAP_MIN, tmin);
    reg_write(REG_TAP_TIMEOUT, tmo);
    reg_write(REG_HOLD, hold);
    reg_write(REG_MAX_DELAY, dmax);
    reg_readback(REG_SAMPLE_RATE);
    reg_readback(REG_TAP_MIN);
    reg_readback(REG_TAP_TIMEOUT);
    reg_readback(REG_HOLD);
    reg_readback(REG_MAX_DELAY);
  endtask

  function automatic ttfc_in_t blank_scan(input logic [31:0] t);
    ttfc_in_t s;
    s        = '0;
    s.now_ms = t;
    return s;
  endfunction

  // Mostly plausible pedal use: time moving forward by tap-sized steps,
  // footswitch two pressed/held/released in order; some pure noise.
  function automatic ttfc_in_t gen_scan();
    ttfc_in_t    s;
    logic [63:0] raw;
    logic [31:0] step;
    int          r;
    s = '0;
    if ($urandom_range(0, 99) < 12) begin
      raw = {$urandom, $urandom};
      s   = raw[$bits(ttfc_in_t)-1:0];
      return s;
    end
    r = $urandom_range(0, 99);
    if (r < 60)      step = $urandom_range(cfg_min, cfg_timeout);
    else if (r < 75) step = $urandom_range(0, 5);
    else if (r < 90) step = $urandom_range(0, 300);
    else             step = 32'(cfg_timeout) + $urandom_range(1, 3000);
    gen_now  += step;
    s.now_ms   = gen_now;
    s.fs1_rise = ($urandom_range(0, 99) < 45);
    s.fs1_down = ($urandom_range(0, 99) < 20);
    if (!gen_fs2_held) begin
      if ($urandom_range(0, 99) < 15) begin
        gen_fs2_held = 1'b1;
        gen_held     = 0;
        s.fs2_rise   = 1'b1;
        s.fs2_down   = 1'b1;
      end
    end else begin
      gen_held = gen_held + int'(step);
      if (gen_held > 65535) gen_held = 65535;
      s.fs2_held_ms = 16'(gen_held);
      if ($urandom_range(0, 99) < 30) begin
        s.fs2_fall   = 1'b1;
        gen_fs2_held = 1'b0;
      end else begin
        s.fs2_down = 1'b1;
      end
    end
    if ($urandom_range(0, 99) < 10) begin
      r = $urandom_range(0, 2);
      gen_tog[r] = ($urandom_range(0, 9) == 0) ? TGL_SPARE : 2'($urandom_range(0, 2));
    end
    s.toggle_one   = gen_tog[0];
    s.toggle_two   = gen_tog[1];
    s.toggle_three = gen_tog[2];
    s.knob_moved   = ($urandom_range(0, 99) < 5);
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Tap timing at reset settings: first tap, min, timeout edge, timeout,
  // knob cancel, time wrap
  task automatic test_tap_timing();
    ttfc_in_t s;
    idle_on = 1'b0;
    send_scan(blank_scan(0));
    s = blank_scan(1000); s.fs1_rise = 1'b1; send_scan(s);
    s = blank_scan(1500); s.fs1_rise = 1'b1; send_scan(s);
    s = blank_scan(1550); s.fs1_rise = 1'b1; send_scan(s);  // shorter than min
    s = blank_scan(2100); s.fs1_rise = 1'b1; send_scan(s);
    s = blank_scan(4100); s.fs1_rise = 1'b1; send_scan(s);  // exactly timeout
    s = blank_scan(6101); s.fs1_rise = 1'b1; send_scan(s);  // one past timeout
    s = blank_scan(6200); s.knob_moved = 1'b1; send_scan(s);
    s = blank_scan(32'hFFFF_FF00); s.fs1_rise = 1'b1; send_scan(s);
    s = blank_scan(32'h0000_0100); s.fs1_rise = 1'b1; send_scan(s);
  endtask

  // Bypass toggle, freeze on hold, send gate, leaving freeze, muted release
  task automatic test_footswitch_two();
    ttfc_in_t s;
    s = blank_scan(200); s.fs2_rise = 1'b1; s.fs2_down = 1'b1; send_scan(s);
    s = blank_scan(210); s.fs2_fall = 1'b1; s.fs2_held_ms = 16'd10; send_scan(s);
    s = blank_scan(300); s.fs2_rise = 1'b1; s.fs2_down = 1'b1; send_scan(s);
    s = blank_scan(800); s.fs2_down = 1'b1; s.fs2_held_ms = 16'd500;
    s.fs1_down = 1'b1; send_scan(s);
    // frozen: gate on, tap and toggle ignored
    s = blank_scan(900); s.fs2_down = 1'b1; s.fs2_held_ms = 16'hFFFF;
    s.fs1_down = 1'b1; s.fs1_rise = 1'b1; s.toggle_three = TGL_MID; send_scan(s);
    s = blank_scan(950); s.fs2_fall = 1'b1; s.fs2_held_ms = 16'hFFFF; send_scan(s);
    s = blank_scan(1000); s.fs2_rise = 1'b1; s.fs2_down = 1'b1; send_scan(s);
    s = blank_scan(1010); s.fs2_fall = 1'b1; s.fs2_held_ms = 16'd10; send_scan(s);
  endtask

  // Hidden modes through toggles with footswitch one held, incl. spare code
  task automatic test_hidden_modes();
    ttfc_in_t s;
    s = blank_scan(1100); s.fs1_down = 1'b1; s.toggle_three = TGL_DOWN; send_scan(s);
    s = blank_scan(1110); s.fs1_down = 1'b1; s.toggle_three = TGL_DOWN;
    s.toggle_two = TGL_MID; send_scan(s);
    s = blank_scan(1120); s.fs1_down = 1'b1; s.toggle_one = TGL_SPARE;
    s.toggle_two = TGL_SPARE; s.toggle_three = TGL_SPARE; send_scan(s);
    send_scan(blank_scan(1130));  // toggles move back, footswitch up
    s = blank_scan(1140); s.fs1_down = 1'b1; s.fs1_rise = 1'b1;
    s.toggle_one = TGL_MID; s.knob_moved = 1'b1; send_scan(s);
    s = '1; send_scan(s);
    drain_scans();
  endtask

  // Register extremes, zeros, masking of upper bits, a mid setting
  task automatic test_config_sweep();
    idle_on = 1'b1;
    gen_now = $urandom;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF);
        1: set_config(0, 0, 0, 0, 0);
        2: set_config(8000, 1, 1, 1, 1);
        3: set_config(192000, 4095, 4095, 65535, 1048575);
        default: set_config($urandom_range(8000, 192000), $urandom_range(1, 400),
                            $urandom_range(400, 4095), $urandom_range(1, 3000),
                            $urandom_range(1, 1048575));
      endcase
      for (int i = 0; i < 40; i++) send_scan(gen_scan());
      drain_scans();
    end
    set_config(RST_SAMPLE_RATE, RST_TAP_MIN, RST_TAP_TIMEOUT, RST_HOLD, RST_MAX_DELAY);
  endtask

  // Long random run, idle stretches switched per chunk, wraps the ms clock
  task automatic test_random_scans();
    gen_now = 32'hFFFF_0000;
    for (int i = 0; i < 350; i++) begin
      if (i == 175) begin
        drain_scans();
        set_config($urandom_range(8000, 192000), $urandom_range(1, 300),
                   $urandom_range(300, 4095), $urandom_range(1, 2000),
                   $urandom_range(1, 1048575));
      end
      if (i % 50 == 0) idle_on = (i != 0) && ($urandom_range(0, 3) != 0);
      send_scan(gen_scan());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, run, limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int k;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    mismatches   = 0;
    idle_on      = 1'b0;
    sink_hold    = 0;
    gen_now      = '0;
    gen_fs2_held = 1'b0;
    gen_held     = 0;
    for (int i = 0; i < 3; i++) gen_tog[i] = TGL_UP;
    reset_controls();
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_tap_timing();
    test_footswitch_two();
    test_hidden_modes();
    test_config_sweep();
    test_random_scans();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    for (k = 0; k < 20000 && pending_ctl.size() != 0; k++) @(posedge clk);
    if (pending_ctl.size() != 0) note_mismatch("beats never returned", pending_ctl.size(), 0);
    // worst case is a full divide pass; anything arriving now is spurious
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
